FILE: rtl/dtsg_pkg.sv
// dtsg_pkg: shared types and constants of the dual-tone key sequence generator
// no dependencies; imported by every rtl module of the block except dtsg_ram

package dtsg_pkg;

    localparam int KEY_W        = 4;
    localparam int COUNT_CFG_W  = 20;
    localparam int AMP_W        = 15;
    localparam int SAMPLE_W     = 16;
    localparam int PENDING_W    = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 20;

    // operation codes of an input beat
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // classified item handed from the front end to the player
    typedef struct packed {
        logic       is_tick;
        logic [1:0] key_row;
        logic [1:0] key_col;
    } item_t;

    typedef struct packed {
        logic [COUNT_CFG_W-1:0] tone_samples;
        logic [COUNT_CFG_W-1:0] gap_samples;
        logic [AMP_W-1:0]       amplitude;
    } cfg_t;

    // row and column tone frequencies in hz
    localparam logic [10:0] ROW_HZ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
    localparam logic [10:0] COL_HZ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

    // sample scaling: (s1 + s2) * amp * fade_num / (2 * 32767 * 9), done as a
    // divide by 32767 (shift-add estimate, one correction) and then by 18
    localparam int                NUMER_W     = 35;
    localparam int                QUO_W       = 15;
    localparam int                COARSE_W    = 21;
    localparam int                FIX_W       = 17;
    localparam logic [FIX_W-1:0]  FULL_SCALE  = 17'd32767;
    localparam int                RECIP_W     = 21;
    // ceil(2^25 / 18), exact for quotients below 2^21
    localparam logic [20:0]       RECIP_18    = 21'd1864136;
    localparam int                RECIP_SHIFT = 25;

endpackage

FILE: rtl/dtsg_ram.sv
// dtsg_ram: generic single write port, single registered read port ram
// no dependencies

module dtsg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/dtsg_front.sv
// dtsg_front: input beat acceptance, key classification and a two-entry item queue
// depends on dtsg_pkg

module dtsg_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [dtsg_pkg::KEY_W-1:0]    s_key_code,
    output logic                          item_valid,
    output dtsg_pkg::item_t               item,
    input  logic                          item_ready
);

    import dtsg_pkg::*;

    // keypad code to row / column index
    localparam logic [1:0] KEY_ROW [16] = '{
        2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
        2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3};
    localparam logic [1:0] KEY_COL [16] = '{
        2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd2};

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    item_t      incoming;
    logic       push, pop;

    assign s_ready    = (fill_reg != 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        incoming.is_tick = (op_t'(s_operation) == OP_TICK);
        incoming.key_row = KEY_ROW[s_key_code];
        incoming.key_col = KEY_COL[s_key_code];
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/dtsg_sine.sv
// dtsg_sine: quarter-wave sine rom with registered lookup of a 32-bit phase
// depends on dtsg_pkg

module dtsg_sine #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                             aclk,
    input  logic [31:0]                      phase,
    output logic [dtsg_pkg::SAMPLE_W-1:0]    value
);

    import dtsg_pkg::*;

    localparam int                       SINE_POINTS = 1 << SINE_TABLE_BITS;
    localparam logic [SINE_TABLE_BITS:0] TOP_INDEX   = {1'b1, {SINE_TABLE_BITS{1'b0}}};
    localparam logic [63:0]              PI_HALF_Q30 = 64'd1686629713;

    // sin(pi/2 * k / points) * 32767 from a q30 taylor series up to x^15
    function automatic logic [14:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] v;
        x   = (PI_HALF_Q30 * 64'(k)) >> SINE_TABLE_BITS;
        x2  = (x * x) >> 30;
        mag = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
            mag = (mag * x2) >> 30;
            unique case (n)
                1:       mag = mag / 64'd6;
                2:       mag = mag / 64'd20;
                3:       mag = mag / 64'd42;
                4:       mag = mag / 64'd72;
                5:       mag = mag / 64'd110;
                6:       mag = mag / 64'd156;
                default: mag = mag / 64'd210;
            endcase
            if ((n % 2) == 1) begin
                sum = (sum >= mag) ? sum - mag : 64'd0;
            end else begin
                sum = sum + mag;
            end
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        return (v > 64'd32767) ? 15'h7fff : v[14:0];
    endfunction

    logic [14:0]                rom [SINE_POINTS + 1];
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS:0]   rom_addr;
    logic [14:0]                mag_reg;
    logic                       neg_reg;

    for (genvar k = 0; k <= SINE_POINTS; k++) begin : g_rom
        assign rom[k] = sine_entry(k);
    end

    assign quad     = phase[31:30];
    assign idx      = phase[29 -: SINE_TABLE_BITS];
    // odd quadrants run the table backwards
    assign rom_addr = quad[0] ? (TOP_INDEX - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge aclk) begin
        mag_reg <= rom[rom_addr];
        neg_reg <= quad[1];
    end

    assign value = neg_reg ? (~{1'b0, mag_reg} + 16'd1) : {1'b0, mag_reg};

endmodule

FILE: rtl/dtsg_back.sv
// dtsg_back: key queue, tone / gap sequencer, sample scaling and result register
// depends on dtsg_pkg, dtsg_ram, dtsg_sine

module dtsg_back #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int SAMPLE_RATE     = 8000,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              item_valid,
    input  dtsg_pkg::item_t                   item,
    output logic                              item_ready,
    input  dtsg_pkg::cfg_t                    cfg,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dtsg_pkg::SAMPLE_W-1:0]     m_sample,
    output logic                              m_playing,
    output logic [dtsg_pkg::PENDING_W-1:0]    m_keys_pending
);

    import dtsg_pkg::*;

    localparam int               AW        = $clog2(QUEUE_DEPTH);
    localparam int               CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int               PROD_W    = COARSE_W + RECIP_W;
    localparam logic [AW:0]      DEPTH_A   = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0]    DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0]    LAST_HEAD = AW'(QUEUE_DEPTH - 1);
    localparam logic [63:0]      HALF_RATE = 64'(SAMPLE_RATE / 2);
    localparam logic [63:0]      RATE      = 64'(SAMPLE_RATE);

    // phase increments, full turn = 2^32, rounded to nearest
    localparam logic [31:0] LOW_INC [4] = '{
        32'(((64'(ROW_HZ[0]) << 32) + HALF_RATE) / RATE),
        32'(((64'(ROW_HZ[1]) << 32) + HALF_RATE) / RATE),
        32'(((64'(ROW_HZ[2]) << 32) + HALF_RATE) / RATE),
        32'(((64'(ROW_HZ[3]) << 32) + HALF_RATE) / RATE)};
    localparam logic [31:0] HIGH_INC [4] = '{
        32'(((64'(COL_HZ[0]) << 32) + HALF_RATE) / RATE),
        32'(((64'(COL_HZ[1]) << 32) + HALF_RATE) / RATE),
        32'(((64'(COL_HZ[2]) << 32) + HALF_RATE) / RATE),
        32'(((64'(COL_HZ[3]) << 32) + HALF_RATE) / RATE)};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SIN_LO,
        ST_SIN_HI,
        ST_MUL_AMP,
        ST_MUL_FADE,
        ST_DIV_EST,
        ST_DIV_FIX,
        ST_DIV_RECIP,
        ST_APPLY,
        ST_DONE
    } state_t;

    // control state
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           head_reg, head_next;
    logic                    in_gap_reg, in_gap_next;
    logic [COUNT_CFG_W-1:0]  remain_reg, remain_next;
    logic [1:0]              fade_reg, fade_next;
    logic [31:0]             low_phase_reg, low_phase_next;
    logic [31:0]             high_phase_reg, high_phase_next;
    logic [31:0]             low_inc_reg, low_inc_next;
    logic [31:0]             high_inc_reg, high_inc_next;
    logic                    m_valid_reg, m_valid_next;

    // datapath
    logic [SAMPLE_W-1:0]     s_lo_reg, s_lo_next;
    logic                    neg_reg, neg_next;
    logic [31:0]             prod_reg, prod_next;
    logic [3:0]              fade_mul_reg, fade_mul_next;
    logic [NUMER_W-1:0]      numer_reg, numer_next;
    logic [COARSE_W-1:0]     coarse_reg, coarse_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [SAMPLE_W-1:0]     res_sample_reg, res_sample_next;
    logic                    res_playing_reg, res_playing_next;
    logic [SAMPLE_W-1:0]     m_sample_reg, m_sample_next;
    logic                    m_playing_reg, m_playing_next;
    logic [PENDING_W-1:0]    m_pending_reg, m_pending_next;

    // key queue and sine lookup
    logic                    ram_wr_en;
    logic [AW-1:0]           tail;
    logic [AW:0]             tail_sum;
    logic [KEY_W-1:0]        ram_rd_data;
    logic [31:0]             sine_phase;
    logic [SAMPLE_W-1:0]     sine_value;

    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign tail     = (tail_sum >= DEPTH_A) ? AW'(tail_sum - DEPTH_A) : AW'(tail_sum);

    dtsg_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail),
        .wr_data ({item.key_row, item.key_col}),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    dtsg_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .aclk  (aclk),
        .phase (sine_phase),
        .value (sine_value)
    );

    assign m_valid        = m_valid_reg;
    assign m_sample       = m_sample_reg;
    assign m_playing      = m_playing_reg;
    assign m_keys_pending = m_pending_reg;

    always_comb begin
        logic [16:0]          sum;
        logic [16:0]          mag;
        logic [1:0]           fade_in;
        logic [2:0]           fade_out;
        logic [2:0]           fade_top;
        logic [NUMER_W-1:0]   numer;
        logic [NUMER_W:0]     est_sum;
        logic [FIX_W-1:0]     fix_rem;
        logic [PROD_W-1:0]    recip_prod;

        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        in_gap_next      = in_gap_reg;
        remain_next      = remain_reg;
        fade_next        = fade_reg;
        low_phase_next   = low_phase_reg;
        high_phase_next  = high_phase_reg;
        low_inc_next     = low_inc_reg;
        high_inc_next    = high_inc_reg;
        m_valid_next     = m_valid_reg;
        s_lo_next        = s_lo_reg;
        neg_next         = neg_reg;
        prod_next        = prod_reg;
        fade_mul_next    = fade_mul_reg;
        numer_next       = numer_reg;
        coarse_next      = coarse_reg;
        quo_next         = quo_reg;
        res_sample_next  = res_sample_reg;
        res_playing_next = res_playing_reg;
        m_sample_next    = m_sample_reg;
        m_playing_next   = m_playing_reg;
        m_pending_next   = m_pending_reg;
        ram_wr_en        = 1'b0;
        item_ready       = 1'b0;
        sine_phase       = low_phase_reg;

        sum      = {s_lo_reg[SAMPLE_W-1], s_lo_reg} + {sine_value[SAMPLE_W-1], sine_value};
        mag      = sum[16] ? (~sum + 17'd1) : sum;
        fade_in  = (fade_reg == 2'd3) ? 2'd3 : fade_reg + 2'd1;
        fade_top = 3'(remain_reg[1:0]) + 3'(fade_reg);
        if (fade_top > 3'd2) begin
            fade_top = 3'd2;
        end
        fade_out = (remain_reg <= COUNT_CFG_W'(2))
                 ? 3'd3 - (fade_top - 3'(remain_reg[1:0]) + 3'd1) : 3'd3;
        numer    = NUMER_W'(prod_reg) * NUMER_W'(fade_mul_reg);

        // quotient by 32767 from (y + y / 2^15) / 2^15, at most one short
        est_sum    = {1'b0, numer_reg} + (NUMER_W + 1)'(numer_reg >> 15);
        // y - q * 32767 stays below 2 * 32767, so 17 wrapping bits are exact
        fix_rem    = numer_reg[FIX_W-1:0] - {coarse_reg[1:0], 15'd0}
                   + coarse_reg[FIX_W-1:0];
        // remaining divide by 18 as a reciprocal multiply
        recip_prod = PROD_W'(coarse_reg) * PROD_W'(RECIP_18);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_ready = 1'b1;
                    if (!item.is_tick) begin
                        if (count_reg < DEPTH_C) begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end else if (in_gap_reg && remain_reg != '0) begin
                        res_playing_next = 1'b1;
                        res_sample_next  = '0;
                        remain_next      = remain_reg - COUNT_CFG_W'(1);
                        if (remain_reg == COUNT_CFG_W'(1)) begin
                            in_gap_next = 1'b0;
                        end
                        state_next = ST_DONE;
                    end else begin
                        in_gap_next = 1'b0;
                        if (remain_reg == '0 && count_reg != '0) begin
                            state_next = ST_LOAD;
                        end else if (remain_reg != '0) begin
                            state_next = ST_SIN_LO;
                        end else begin
                            res_playing_next = 1'b0;
                            res_sample_next  = '0;
                            state_next       = ST_DONE;
                        end
                    end
                end
            end
            ST_LOAD: begin
                low_inc_next    = LOW_INC[ram_rd_data[3:2]];
                high_inc_next   = HIGH_INC[ram_rd_data[1:0]];
                low_phase_next  = '0;
                high_phase_next = '0;
                fade_next       = 2'd0;
                head_next       = (head_reg == LAST_HEAD) ? '0 : head_reg + AW'(1);
                count_next      = count_reg - CW'(1);
                if (cfg.tone_samples == '0) begin
                    res_playing_next = 1'b1;
                    res_sample_next  = '0;
                    in_gap_next      = 1'b1;
                    remain_next      = cfg.gap_samples;
                    state_next       = ST_DONE;
                end else begin
                    remain_next = cfg.tone_samples;
                    state_next  = ST_SIN_LO;
                end
            end
            ST_SIN_LO: begin
                sine_phase = low_phase_reg;
                state_next = ST_SIN_HI;
            end
            ST_SIN_HI: begin
                sine_phase = high_phase_reg;
                s_lo_next  = sine_value;
                state_next = ST_MUL_AMP;
            end
            ST_MUL_AMP: begin
                neg_next      = sum[16];
                prod_next     = 32'(mag) * 32'(cfg.amplitude);
                fade_mul_next = 4'(fade_in) * 4'(fade_out[1:0]);
                state_next    = ST_MUL_FADE;
            end
            ST_MUL_FADE: begin
                numer_next = numer;
                state_next = ST_DIV_EST;
            end
            ST_DIV_EST: begin
                coarse_next = est_sum[NUMER_W -: COARSE_W];
                state_next  = ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
                if (fix_rem >= FULL_SCALE) begin
                    coarse_next = coarse_reg + COARSE_W'(1);
                end
                state_next = ST_DIV_RECIP;
            end
            ST_DIV_RECIP: begin
                quo_next   = recip_prod[RECIP_SHIFT +: QUO_W];
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                res_sample_next  = neg_reg ? (~{1'b0, quo_reg} + SAMPLE_W'(1))
                                           : {1'b0, quo_reg};
                res_playing_next = 1'b1;
                low_phase_next   = low_phase_reg + low_inc_reg;
                high_phase_next  = high_phase_reg + high_inc_reg;
                if (fade_reg != 2'd3) begin
                    fade_next = fade_reg + 2'd1;
                end
                if (remain_reg == COUNT_CFG_W'(1)) begin
                    in_gap_next = 1'b1;
                    remain_next = cfg.gap_samples;
                end else begin
                    remain_next = remain_reg - COUNT_CFG_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_sample_next  = res_sample_reg;
                    m_playing_next = res_playing_reg;
                    m_pending_next = PENDING_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        s_lo_reg        <= s_lo_next;
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        fade_mul_reg    <= fade_mul_next;
        numer_reg       <= numer_next;
        coarse_reg      <= coarse_next;
        quo_reg         <= quo_next;
        res_sample_reg  <= res_sample_next;
        res_playing_reg <= res_playing_next;
        m_sample_reg    <= m_sample_next;
        m_playing_reg   <= m_playing_next;
        m_pending_reg   <= m_pending_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            in_gap_reg     <= 1'b0;
            remain_reg     <= '0;
            fade_reg       <= 2'd0;
            low_phase_reg  <= '0;
            high_phase_reg <= '0;
            low_inc_reg    <= '0;
            high_inc_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            in_gap_reg     <= in_gap_next;
            remain_reg     <= remain_next;
            fade_reg       <= fade_next;
            low_phase_reg  <= low_phase_next;
            high_phase_reg <= high_phase_next;
            low_inc_reg    <= low_inc_next;
            high_inc_reg   <= high_inc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

FILE: rtl/dtmf_tone_sequence_generator.sv
// dtmf_tone_sequence_generator: top level, configuration registers and the two halves
// depends on dtsg_pkg, dtsg_front, dtsg_back (which uses dtsg_ram and dtsg_sine)

// Keypad tone sequencer. A push beat (operation 0) queues a key code (0-9, A-D,
// star, hash) and returns nothing; a tick beat (operation 1) returns one signed
// 16-bit sample with playing and keys_pending. Each queued key plays
// tone_samples samples of row plus column tone at amplitude/2 peak per tone,
// faded in over three samples and out over two, then gap_samples of silence.
// A push into a full queue is dropped; a tick with nothing to play gives zero.
// A push is handled in the player's idle state; a silent or gap tick goes from
// idle to the result state, and the tick that starts a key first loads it from
// the key queue. A tone tick runs two lookups through the single sine rom port,
// two multiply stages and a constant divide (shift-add estimate of the quotient
// by 32767, one correction step, then a reciprocal multiply for the remaining
// factor of 18). A two-entry queue in front of the player keeps taking beats
// while it works, and the result register keeps the player going while a result
// waits on m_ready.
// Configuration writes are taken every cycle and should only be issued while
// the block is idle.

module dtmf_tone_sequence_generator #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int SAMPLE_RATE     = 8000,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [dtsg_pkg::KEY_W-1:0]         s_key_code,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dtsg_pkg::SAMPLE_W-1:0]      m_sample,
    output logic                               m_playing,
    output logic [dtsg_pkg::PENDING_W-1:0]     m_keys_pending,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dtsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dtsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import dtsg_pkg::*;

    // register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TONE_SAMPLES = 2'd0,
        REG_GAP_SAMPLES  = 2'd1,
        REG_AMPLITUDE    = 2'd2
    } reg_index_t;

    cfg_t   cfg_reg, cfg_next;
    logic   item_valid;
    logic   item_ready;
    item_t  item;

    // writes are always accepted and registered in cfg_reg
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TONE_SAMPLES: cfg_next.tone_samples = cfg_data;
                REG_GAP_SAMPLES:  cfg_next.gap_samples  = cfg_data;
                REG_AMPLITUDE:    cfg_next.amplitude    = cfg_data[AMP_W-1:0];
                default:          cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tone_samples <= COUNT_CFG_W'(800);
            cfg_reg.gap_samples  <= COUNT_CFG_W'(800);
            cfg_reg.amplitude    <= AMP_W'(16000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accepts beats, maps keys to row / column, buffers two items
    dtsg_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key_code  (s_key_code),
        .item_valid  (item_valid),
        .item        (item),
        .item_ready  (item_ready)
    );

    // player: key queue, tone and gap sequencing, sample arithmetic, result beat
    dtsg_back #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (item_valid),
        .item           (item),
        .item_ready     (item_ready),
        .cfg            (cfg_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_playing      (m_playing),
        .m_keys_pending (m_keys_pending)
    );

endmodule

FILE: verif/dtmf_tone_sequence_generator_tb.sv
// dtmf_tone_sequence_generator_tb: self-checking testbench for the keypad tone sequencer
// depends on dtsg_pkg and the rtl top dtmf_tone_sequence_generator; reads no files

module dtmf_tone_sequence_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtsg_pkg::*;

    typedef longint unsigned u64_t;

    // register indexes on the write channel
    localparam logic [CFG_INDEX_W-1:0] REG_TONE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMP   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam int     KEY_DEPTH      = 16;
    localparam int     ROM_POINTS     = 1024;
    localparam longint SCALE_DIVISOR  = 2 * 32767 * 9;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     TAIL_CYCLES    = 30;
    localparam int     WATCHDOG_LIMIT = 3000;

    // row and column frequency of each key code (0-9, A-D, star, hash)
    localparam int KEY_ROW_HZ [16] = '{941, 697, 697, 697, 770, 770, 770, 852,
                                       852, 852, 697, 770, 852, 941, 941, 941};
    localparam int KEY_COL_HZ [16] = '{1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209,
                                       1336, 1477, 1633, 1633, 1633, 1633, 1209, 1477};

    typedef struct {
        logic [SAMPLE_W-1:0]  sample;
        logic                 playing;
        logic [PENDING_W-1:0] pending;
    } sample_beat_t;

    // mirror of the sequencer: key fifo, tone player and the samples it must emit
    class tone_scoreboard;
        logic [COUNT_CFG_W-1:0] tone_len;
        logic [COUNT_CFG_W-1:0] gap_len;
        logic [AMP_W-1:0]       amp;
        logic [KEY_W-1:0]       key_fifo [KEY_DEPTH];
        int                     fifo_head;
        int                     fifo_count;
        logic [31:0]            low_phase;
        logic [31:0]            high_phase;
        logic [31:0]            low_inc;
        logic [31:0]            high_inc;
        logic [COUNT_CFG_W-1:0] remaining;
        bit                     in_gap;
        int                     fade_step;
        int                     quarter_sine [ROM_POINTS + 1];
        sample_beat_t           expected_samples [$];
        int                     mismatches;
        int                     n_push;
        int                     n_drop;
        int                     n_results;
        int                     n_writes;

        function new();
            u64_t x, x2, mag, total, v;
            for (int k = 0; k <= ROM_POINTS; k++) begin
                // q30 taylor series of sin up to the x^15 term
                x = k;
                x = x * 64'd1686629713 / u64_t'(ROM_POINTS);
                x2 = (x * x) >> 30;
                mag = x;
                total = x;
                for (int n = 1; n <= 7; n++) begin
                    mag = ((mag * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        total = (total >= mag) ? total - mag : 64'd0;
                    else
                        total += mag;
                end
                v = (total * 64'd32767 + (64'd1 << 29)) >> 30;
                quarter_sine[k] = (v > 64'd32767) ? 32767 : int'(v);
            end
            tone_len = 20'd800;
            gap_len = 20'd800;
            amp = 15'd16000;
            foreach (key_fifo[i]) key_fifo[i] = '0;
            fifo_head = 0;
            fifo_count = 0;
            low_phase = '0;
            high_phase = '0;
            low_inc = '0;
            high_inc = '0;
            remaining = '0;
            in_gap = 0;
            fade_step = 0;
            mismatches = 0;
            n_push = 0;
            n_drop = 0;
            n_results = 0;
            n_writes = 0;
        endfunction

        function logic [31:0] phase_step(int hz);
            u64_t acc;
            acc = hz;
            acc = ((acc << 32) + 64'd4000) / 64'd8000;
            return acc[31:0];
        endfunction

        function int sine_of(logic [31:0] ph);
            int idx;
            int v;
            idx = ph[29:20];
            if (ph[30])
                idx = ROM_POINTS - idx;
            v = quarter_sine[idx];
            return ph[31] ? -v : v;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            n_writes++;
            case (idx)
                REG_TONE: tone_len = data;
                REG_GAP:  gap_len = data;
                REG_AMP:  amp = data[AMP_W-1:0];
                default: ;
            endcase
        endfunction

        function sample_beat_t predict_tick();
            sample_beat_t r;
            logic [KEY_W-1:0] key;
            int fi, fo, top, rem_i, total;
            longint scaled;
            r.sample = '0;
            r.playing = 1'b0;
            if (in_gap && remaining == 0)
                in_gap = 0;
            if (in_gap) begin
                r.playing = 1'b1;
                remaining--;
                if (remaining == 0)
                    in_gap = 0;
            end else begin
                if (remaining == 0 && fifo_count > 0) begin
                    key = key_fifo[fifo_head];
                    fifo_head = (fifo_head + 1) % KEY_DEPTH;
                    fifo_count--;
                    low_inc = phase_step(KEY_ROW_HZ[key]);
                    high_inc = phase_step(KEY_COL_HZ[key]);
                    low_phase = '0;
                    high_phase = '0;
                    fade_step = 0;
                    remaining = tone_len;
                    if (remaining == 0) begin
                        r.playing = 1'b1;
                        in_gap = 1;
                        remaining = gap_len;
                    end
                end
                if (!in_gap && remaining > 0) begin
                    rem_i = remaining;
                    fi = (fade_step + 1 > 3) ? 3 : fade_step + 1;
                    fo = 3;
                    if (rem_i <= 2) begin
                        top = (rem_i + fade_step > 2) ? 2 : rem_i + fade_step;
                        fo = 3 - (top - rem_i + 1);
                    end
                    total = sine_of(low_phase) + sine_of(high_phase);
                    scaled = longint'(total) * longint'(amp) * longint'(fi * fo)
                             / SCALE_DIVISOR;
                    r.sample = scaled[SAMPLE_W-1:0];
                    r.playing = 1'b1;
                    low_phase += low_inc;
                    high_phase += high_inc;
                    if (fade_step < 3)
                        fade_step++;
                    remaining--;
                    if (remaining == 0) begin
                        in_gap = 1;
                        remaining = gap_len;
                    end
                end
            end
            r.pending = PENDING_W'(fifo_count);
            return r;
        endfunction

        function void note_beat(op_t op, logic [KEY_W-1:0] key);
            if (op == OP_PUSH) begin
                n_push++;
                if (fifo_count < KEY_DEPTH) begin
                    key_fifo[(fifo_head + fifo_count) % KEY_DEPTH] = key;
                    fifo_count++;
                end else begin
                    n_drop++;
                end
            end else begin
                expected_samples.push_back(predict_tick());
            end
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] s, logic p, logic [PENDING_W-1:0] k);
            sample_beat_t e;
            n_results++;
            if (expected_samples.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected: sample %0d playing %0b pending %0d",
                         $time, $signed(s), p, k);
                return;
            end
            e = expected_samples.pop_front();
            if (s !== e.sample) begin
                mismatches++;
                $display("%0t: sample mismatch: expected %0d, actual %0d",
                         $time, $signed(e.sample), $signed(s));
            end
            if (p !== e.playing) begin
                mismatches++;
                $display("%0t: playing mismatch: expected %0b, actual %0b", $time, e.playing, p);
            end
            if (k !== e.pending) begin
                mismatches++;
                $display("%0t: keys_pending mismatch: expected %0d, actual %0d",
                         $time, e.pending, k);
            end
        endfunction

        function int outstanding();
            return expected_samples.size();
        endfunction

        // no key queued and nothing playing, so ticks are silent
        function bit quiet();
            return fifo_count == 0 && remaining == 0;
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_operation;
    logic [KEY_W-1:0]       s_key_code;
    logic                   m_valid;
    logic                   m_ready;
    logic [SAMPLE_W-1:0]    m_sample;
    logic                   m_playing;
    logic [PENDING_W-1:0]   m_keys_pending;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tone_scoreboard sb;

    // idling switches and the hold-off flags, one writer each
    bit src_idle;
    bit snk_idle;
    bit hold_req;
    bit hold_done;

    dtmf_tone_sequence_generator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_key_code     (s_key_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_playing      (m_playing),
        .m_keys_pending (m_keys_pending),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 100 mhz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: every beat taken is checked against the oldest expected sample
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_sample(m_sample, m_playing, m_keys_pending);
    end

    // result side ready: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_done = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                // long hold-off so the block backs up and drops s_ready
                hold_done = 1;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready = 1'b1;
            end else if (snk_idle && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // watchdog: cycles in a row with no beat moving on any channel
    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: timeout, no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // offer one input beat, with an optional idle burst first; returns at acceptance
    task automatic put_beat(op_t op, logic [KEY_W-1:0] key);
        @(negedge aclk);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_key_code = key;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(op, key);
    endtask

    task automatic tick_run(int n);
        for (int i = 0; i < n; i++)
            put_beat(OP_TICK, KEY_W'($urandom_range(0, 15)));
    endtask

    // ticks, with pushes mixed in at the given percentage
    task automatic random_phase(int n_items, int push_pct);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < push_pct)
                put_beat(OP_PUSH, KEY_W'($urandom_range(0, 15)));
            else
                put_beat(OP_TICK, KEY_W'($urandom_range(0, 15)));
        end
    endtask

    // tick until the fifo is empty and the current key is done
    task automatic drain_keys();
        while (!sb.quiet())
            put_beat(OP_TICK, KEY_W'($urandom_range(0, 15)));
    endtask

    // drop valid, collect every expected sample, then let a trailing push retire
    task automatic wait_idle(int extra);
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle(SETTLE_CYCLES);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // amplitude goes out with random junk above bit 14 to check the masking
    task automatic set_config(int tone, int gap, int amplitude);
        cfg_write(REG_TONE, COUNT_CFG_W'(tone));
        cfg_write(REG_GAP, COUNT_CFG_W'(gap));
        cfg_write(REG_AMP, {5'($urandom), AMP_W'(amplitude)});
    endtask

    initial begin
        s_valid = 1'b0;
        s_operation = OP_PUSH;
        s_key_code = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TONE;
        cfg_data = '0;
        aresetn = 1'b0;
        src_idle = 0;
        snk_idle = 0;
        hold_req = 0;
        sb = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: nothing queued, tick must be silent with playing low
        put_beat(OP_TICK, 4'hF);

        // every key code, then one more push into the full fifo (dropped)
        set_config(4, 0, 32767);
        for (int k = 0; k < KEY_DEPTH; k++)
            put_beat(OP_PUSH, KEY_W'(k));
        put_beat(OP_PUSH, 4'hF);
        // full fade in and fade out of the first key, next key starts with no gap
        tick_run(6);

        // zero tone length: each key gives one playing tick of zero, back to back
        set_config(0, 0, 32767);
        tick_run(5);
        // zero tone length followed by a short gap
        set_config(0, 2, 20000);
        tick_run(4);

        // random part, register changes land mid-key
        src_idle = 1;
        snk_idle = 1;
        set_config(1, 0, 0);
        random_phase(120, 35);

        snk_idle = 0;
        set_config(2, 1, 32767);
        random_phase(150, 30);

        snk_idle = 1;
        src_idle = 0;
        set_config(3, 2, $urandom_range(0, 32767));
        random_phase(150, 25);

        // push heavy, fifo overflows; result side holds off once in here
        src_idle = 1;
        set_config($urandom_range(4, 12), $urandom_range(0, 5), $urandom_range(0, 32767));
        hold_req = 1;
        random_phase(300, 60);

        set_config(2, 0, $urandom_range(0, 32767));
        drain_keys();

        // longer tones walk the phases further round
        set_config(40, 3, $urandom_range(0, 32767));
        random_phase(200, 3);

        set_config(1, 0, $urandom_range(0, 32767));
        drain_keys();

        // top values of every register while nothing plays, plus the unused index
        cfg_write(REG_TONE, 20'hFFFFF);
        cfg_write(REG_GAP, 20'hFFFFF);
        cfg_write(REG_AMP, 20'hFFFFF);
        cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
        tick_run(3);

        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(1, 10), $urandom_range(0, 4),
                       $urandom_range(0, 32767));
            random_phase(120, $urandom_range(10, 50));
        end

        // last stretch at full rate on both sides
        src_idle = 0;
        snk_idle = 0;
        set_config(5, 1, $urandom_range(0, 32767));
        random_phase(150, 20);

        wait_idle(TAIL_CYCLES);

        $display("run covered %0d pushes (%0d dropped on a full fifo) and %0d samples checked",
                 sb.n_push, sb.n_drop, sb.n_results);
        $display("across %0d register writes, %0d mismatches", sb.n_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0t: %0d samples never arrived", $time, sb.outstanding());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
